>>> rtl/core/energy_weighted_centroid_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the energy-weighted centroid block.
// Every property is clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ENERGY_WEIGHTED_CENTROID_MACROS_SVH
`define ENERGY_WEIGHTED_CENTROID_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EWC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/ewc_pkg.sv
// ----------------------------------------------------------------------------
// ewc_pkg
// Shared widths, limits, controller states and command/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ewc_pkg;

    localparam int MAX_HITS  = 256;
    localparam int ENERGY_W  = 24;
    localparam int POS_W     = 20;
    localparam int ESUM_W    = 32;
    localparam int WSUM_W    = 52;
    localparam int PROD_W    = ENERGY_W + 1 + POS_W;
    localparam int DIV_STEPS = WSUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_DIV,
        S_DONE
    } ewc_state_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic out_load;
    } ewc_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } ewc_status_t;

endpackage

>>> rtl/core/energy_weighted_centroid.sv
// ----------------------------------------------------------------------------
// energy_weighted_centroid
// Energy-weighted 3D centroid of a calorimeter cluster, one hit per request.
// ----------------------------------------------------------------------------
// Hits of one cluster arrive one request at a time; the request flagged with
// last_hit closes the cluster and yields exactly one result request carrying
// the centroid, the total energy and a zero-energy flag. An ordinary hit is
// first captured, with its three energy-times-position products registered,
// and then added into the saturating sums. The last hit also passes on
// through one divider load, 52 divide steps and one result load, in the
// radix-2 restoring dividers, one quotient bit per cycle over the 52-bit
// weighted sums; the three coordinates divide in parallel lanes. If
// the previous result is still held by out_stall, the hand-off waits for it.
// Only the first MAX_HITS hits of a cluster enter the sums; later hits are
// dropped but a later last_hit still closes the cluster. Positions are
// truncated toward zero and clamped to the 20-bit range. A cluster with zero
// total energy reports zero position, zero energy and zero_energy high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module energy_weighted_centroid
    import ewc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Hit channel.
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ENERGY_W-1:0]     hit_energy,
    input  logic signed [POS_W-1:0] hit_x,
    input  logic signed [POS_W-1:0] hit_y,
    input  logic signed [POS_W-1:0] hit_z,
    input  logic                    last_hit,

    // Result channel.
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] center_x,
    output logic signed [POS_W-1:0] center_y,
    output logic signed [POS_W-1:0] center_z,
    output logic [ESUM_W-1:0]       cluster_energy,
    output logic                    zero_energy
);

    // The controller only issues commands; all arithmetic sits in the datapath.
    ewc_cmd_t    cmd;
    ewc_status_t status;

    ewc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    ewc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .hit_energy     (hit_energy),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .hit_z          (hit_z),
        .last_hit       (last_hit),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .center_x       (center_x),
        .center_y       (center_y),
        .center_z       (center_z),
        .cluster_energy (cluster_energy),
        .zero_energy    (zero_energy)
    );

endmodule

>>> rtl/core/ewc_div.sv
// ----------------------------------------------------------------------------
// ewc_div
// One restoring divider lane: one quotient bit per step, then a signed
// result clamped to the position range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewc_div
    import ewc_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [WSUM_W-1:0]       dividend_mag,
    input  logic                    dividend_neg,
    input  logic [ESUM_W-1:0]       divisor,
    output logic signed [POS_W-1:0] result
);

    localparam logic [WSUM_W-1:0] POS_MAX_MAG = WSUM_W'((1 << (POS_W - 1)) - 1);
    localparam logic [WSUM_W-1:0] NEG_MAX_MAG = WSUM_W'(1 << (POS_W - 1));

    logic [ESUM_W:0]    rem_reg,  rem_next;
    logic [WSUM_W-1:0]  quo_reg,  quo_next;
    logic [ESUM_W-1:0]  dvs_reg,  dvs_next;
    logic               neg_reg,  neg_next;
    logic [ESUM_W:0]    rem_shift;
    logic [ESUM_W:0]    rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg[ESUM_W-1:0], quo_reg[WSUM_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (load)
        begin
            rem_next = '0;
            quo_next = dividend_mag;
            dvs_next = divisor;
            neg_next = dividend_neg;
        end
        else if (step)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff;
                quo_next = {quo_reg[WSUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[WSUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // The quotient magnitude is truncated toward zero; the sign is applied last.
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > NEG_MAX_MAG)
                result = {1'b1, {(POS_W-1){1'b0}}};
            else
                result = ~quo_reg[POS_W-1:0] + POS_W'(1);
        end
        else
        begin
            if (quo_reg > POS_MAX_MAG)
                result = {1'b0, {(POS_W-1){1'b1}}};
            else
                result = quo_reg[POS_W-1:0];
        end
    end

endmodule

>>> rtl/core/ewc_ctrl.sv
// ----------------------------------------------------------------------------
// ewc_ctrl
// Sequencer: hit capture, accumulation, division steps and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewc_ctrl
    import ewc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  ewc_status_t status,
    output ewc_cmd_t    cmd,
    output logic        in_stall
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    ewc_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg,  step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.last ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ewc_dp.sv
// ----------------------------------------------------------------------------
// ewc_dp
// Datapath: product registers, saturating sums, three divider lanes and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewc_dp
    import ewc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ewc_cmd_t                cmd,
    output ewc_status_t             status,
    input  logic [ENERGY_W-1:0]     hit_energy,
    input  logic signed [POS_W-1:0] hit_x,
    input  logic signed [POS_W-1:0] hit_y,
    input  logic signed [POS_W-1:0] hit_z,
    input  logic                    last_hit,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic signed [POS_W-1:0] center_x,
    output logic signed [POS_W-1:0] center_y,
    output logic signed [POS_W-1:0] center_z,
    output logic [ESUM_W-1:0]       cluster_energy,
    output logic                    zero_energy
);

    localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};
    localparam logic [HIT_CNT_W-1:0]     CNT_LIMIT = HIT_CNT_W'(MAX_HITS);

    // Adds a product to a weighted sum and clamps to the sum's range.
    function automatic logic signed [WSUM_W-1:0] wsum_sat(
        input logic signed [WSUM_W-1:0] acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [WSUM_W:0]   s;
        logic signed [WSUM_W-1:0] r;
        s = {acc[WSUM_W-1], acc} + {{(WSUM_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        if (s[WSUM_W] != s[WSUM_W-1])
            r = s[WSUM_W] ? WSUM_MIN : WSUM_MAX;
        else
            r = s[WSUM_W-1:0];
        return r;
    endfunction

    logic [ENERGY_W-1:0]        energy_reg;
    logic signed [PROD_W-1:0]   prod_x_reg, prod_y_reg, prod_z_reg;
    logic                       last_reg;

    logic [ESUM_W-1:0]          esum_reg,  esum_next;
    logic signed [WSUM_W-1:0]   wx_reg,    wx_next;
    logic signed [WSUM_W-1:0]   wy_reg,    wy_next;
    logic signed [WSUM_W-1:0]   wz_reg,    wz_next;
    logic [HIT_CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [ESUM_W:0]            esum_wide;

    logic [ESUM_W-1:0]          div_energy_reg;
    logic                       div_zero_reg;

    logic signed [POS_W-1:0]    quo_x, quo_y, quo_z;

    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]    cx_reg, cy_reg, cz_reg;
    logic [ESUM_W-1:0]          ce_reg;
    logic                       ze_reg;

    // Capture the hit and register the three products.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            energy_reg <= hit_energy;
            prod_x_reg <= $signed({1'b0, hit_energy}) * hit_x;
            prod_y_reg <= $signed({1'b0, hit_energy}) * hit_y;
            prod_z_reg <= $signed({1'b0, hit_energy}) * hit_z;
            last_reg   <= last_hit;
        end
    end

    always_comb
    begin
        esum_wide = {1'b0, esum_reg} + (ESUM_W+1)'(energy_reg);
        esum_next = esum_reg;
        wx_next   = wx_reg;
        wy_next   = wy_reg;
        wz_next   = wz_reg;
        cnt_next  = cnt_reg;
        if (cmd.div_load)
        begin
            esum_next = '0;
            wx_next   = '0;
            wy_next   = '0;
            wz_next   = '0;
            cnt_next  = '0;
        end
        else if (cmd.accumulate && (cnt_reg < CNT_LIMIT))
        begin
            esum_next = esum_wide[ESUM_W] ? {ESUM_W{1'b1}} : esum_wide[ESUM_W-1:0];
            wx_next   = wsum_sat(wx_reg, prod_x_reg);
            wy_next   = wsum_sat(wy_reg, prod_y_reg);
            wz_next   = wsum_sat(wz_reg, prod_z_reg);
            cnt_next  = cnt_reg + HIT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg <= '0;
            wx_reg   <= '0;
            wy_reg   <= '0;
            wz_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            esum_reg <= esum_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            wz_reg   <= wz_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_energy_reg <= esum_reg;
            div_zero_reg   <= (esum_reg == '0);
        end
    end

    ewc_div u_div_x (
        .clk          (clk),
        .load         (cmd.div_load),
        .step         (cmd.div_step),
        .dividend_mag (wx_reg[WSUM_W-1] ? WSUM_W'(-wx_reg) : WSUM_W'(wx_reg)),
        .dividend_neg (wx_reg[WSUM_W-1]),
        .divisor      (esum_reg),
        .result       (quo_x)
    );

    ewc_div u_div_y (
        .clk          (clk),
        .load         (cmd.div_load),
        .step         (cmd.div_step),
        .dividend_mag (wy_reg[WSUM_W-1] ? WSUM_W'(-wy_reg) : WSUM_W'(wy_reg)),
        .dividend_neg (wy_reg[WSUM_W-1]),
        .divisor      (esum_reg),
        .result       (quo_y)
    );

    ewc_div u_div_z (
        .clk          (clk),
        .load         (cmd.div_load),
        .step         (cmd.div_step),
        .dividend_mag (wz_reg[WSUM_W-1] ? WSUM_W'(-wz_reg) : WSUM_W'(wz_reg)),
        .dividend_neg (wz_reg[WSUM_W-1]),
        .divisor      (esum_reg),
        .result       (quo_z)
    );

    // Result register: frees up when the request is taken downstream.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cx_reg <= div_zero_reg ? '0 : quo_x;
            cy_reg <= div_zero_reg ? '0 : quo_y;
            cz_reg <= div_zero_reg ? '0 : quo_z;
            ce_reg <= div_energy_reg;
            ze_reg <= div_zero_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign center_x       = cx_reg;
    assign center_y       = cy_reg;
    assign center_z       = cz_reg;
    assign cluster_energy = ce_reg;
    assign zero_energy    = ze_reg;

endmodule

>>> rtl/core/ewc_checker.sv
// ----------------------------------------------------------------------------
// ewc_checker
// Port-level checks for the centroid block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "energy_weighted_centroid_macros.svh"

module ewc_checker
    import ewc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [POS_W-1:0] center_x,
    input  logic signed [POS_W-1:0] center_y,
    input  logic signed [POS_W-1:0] center_z,
    input  logic [ESUM_W-1:0]       cluster_energy,
    input  logic                    zero_energy
);

    // A zero-energy cluster reports an all-zero position and energy.
    `EWC_ASSERT_SAME(a_zero_result, clk, rst_n, out_valid && zero_energy, center_x == '0 && center_y == '0 && center_z == '0 && cluster_energy == '0)

    // A normal result always carries a nonzero energy.
    `EWC_ASSERT_SAME(a_energy_nonzero, clk, rst_n, out_valid && !zero_energy, cluster_energy != '0)

    // Every accepted hit is followed by a stall of the hit channel.
    `EWC_ASSERT_NEXT(a_busy_after_hit, clk, rst_n, in_valid && !in_stall, in_stall)

    // A stalled result request holds its contents.
    `EWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(center_x) && $stable(center_y) && $stable(center_z) && $stable(cluster_energy) && $stable(zero_energy))

endmodule

bind energy_weighted_centroid ewc_checker u_ewc_checker (.*);
